FILE: design/perceptron_branch_predictor_core_defines.svh
// assertion macros for the perceptron branch predictor checker
`ifndef PERCEPTRON_BRANCH_PREDICTOR_CORE_DEFINES_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbp check failed");

// next-cycle implication, sampled on clk, off during reset
`define PBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbp check failed");

`endif

FILE: design/pbp_pkg.sv
// shared types and constants of the perceptron branch predictor
`default_nettype none

package pbp_pkg;

    localparam int WEIGHT_W = 8;
    localparam int SUM_W    = 12;
    localparam int THRESH_W = 11;

    localparam int SUM_MAX = 2047;
    localparam int SUM_MIN = -2048;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 11'd5;

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX  = 8'sd127;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN  = -8'sd128;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_STEP = 8'sd1;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_TRAIN   = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SUM
    } state_t;

    function automatic logic [WEIGHT_W-1:0] sat_step(input logic signed [WEIGHT_W-1:0] w,
                                                      input logic up);
        logic [WEIGHT_W-1:0] res;
        if (up)
        begin
            res = (w == WEIGHT_MAX) ? w : w + WEIGHT_STEP;
        end
        else
        begin
            res = (w == WEIGHT_MIN) ? w : w - WEIGHT_STEP;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/pbp_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none

module pbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/pbp_row_update.sv
// per-lane saturating weight update for one training row
`default_nettype none

module pbp_row_update import pbp_pkg::*; #(
    parameter int HISTORY_BITS = 15
) (
    input  wire logic [(HISTORY_BITS+1)*WEIGHT_W-1:0] row_in,
    input  wire logic [HISTORY_BITS-1:0]              history,
    input  wire logic                                 outcome,
    output logic      [(HISTORY_BITS+1)*WEIGHT_W-1:0] row_out
);

    genvar i;
    generate
        for (i = 0; i < HISTORY_BITS; i++)
        begin : g_lane
            assign row_out[i*WEIGHT_W +: WEIGHT_W] =
                sat_step(row_in[i*WEIGHT_W +: WEIGHT_W], outcome == history[i]);
        end
    endgenerate

    // bias lane
    assign row_out[HISTORY_BITS*WEIGHT_W +: WEIGHT_W] =
        sat_step(row_in[HISTORY_BITS*WEIGHT_W +: WEIGHT_W], outcome);

endmodule

`default_nettype wire

FILE: design/pbp_dot_unit.sv
// serial dot product of a weight row with the history signs, one weight a cycle
`default_nettype none

module pbp_dot_unit import pbp_pkg::*; #(
    parameter int HISTORY_BITS = 15
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 load,
    input  wire logic [(HISTORY_BITS+1)*WEIGHT_W-1:0] row_data,
    input  wire logic [HISTORY_BITS-1:0]              history,
    output logic                                      done,
    output logic signed [SUM_W-1:0]                   sum
);

    localparam int ROW_LEN = HISTORY_BITS + 1;
    localparam int ROW_W   = ROW_LEN * WEIGHT_W;
    localparam int IDX_W   = (HISTORY_BITS > 1) ? $clog2(HISTORY_BITS) : 1;
    localparam int RAW_W   = $clog2(ROW_LEN * 128) + 2;
    localparam int ACC_W   = (RAW_W > SUM_W) ? RAW_W : SUM_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SUM_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(SUM_MIN);
    localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(HISTORY_BITS - 1);

    logic [ROW_W-1:0]          row_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      run_reg;
    logic                      done_reg;
    logic signed [SUM_W-1:0]   sum_reg;

    logic signed [WEIGHT_W-1:0] weight;
    logic signed [WEIGHT_W-1:0] bias;
    logic signed [ACC_W-1:0]    weight_ext;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [SUM_W-1:0]    sum_next;
    logic                       last_step;

    assign weight     = row_reg[idx_reg*WEIGHT_W +: WEIGHT_W];
    assign bias       = row_data[HISTORY_BITS*WEIGHT_W +: WEIGHT_W];
    assign weight_ext = ACC_W'(weight);
    assign acc_next   = history[idx_reg] ? acc_reg + weight_ext : acc_reg - weight_ext;
    assign last_step  = (idx_reg == IDX_LAST);

    always_comb
    begin
        if (acc_next > ACC_MAX)
        begin
            sum_next = SUM_W'(SUM_MAX);
        end
        else if (acc_next < ACC_MIN)
        begin
            sum_next = SUM_W'(SUM_MIN);
        end
        else
        begin
            sum_next = SUM_W'(acc_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= row_data;
            acc_reg <= ACC_W'(bias);
            idx_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && last_step;
            if (load)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && last_step)
            begin
                run_reg <= 1'b0;
                sum_reg <= sum_next;
            end
        end
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

`default_nettype wire

FILE: design/perceptron_branch_predictor_core.sv
// top level of the perceptron branch predictor
//
// command channel: a word is taken at a rising edge with start high and busy low.
// command predict looks up the row of pc and returns one result word; command
// train updates the row of pc from the last sum and outcome and returns nothing.
// result channel: valid is high for exactly one cycle with taken and
// perceptron_sum; the receiver cannot stall, so there is no back-pressure.
// predict: the row is read in READ, loaded into the accumulator, which walks
// the row one weight per cycle in SUM; valid comes when the walk ends, and the
// block returns to IDLE after valid to take the next word.
// train: one row read; written back if wrong or |last sum| <= threshold.
// the weight ram holds one row per word, 2**ROW_INDEX_BITS words.
// reset: history and last sum clear, threshold returns to 5, then a clearing
// pass writes every row to zero with busy high.
// the threshold register is written via wr_en / wr_data at any edge.
`default_nettype none

module perceptron_branch_predictor_core import pbp_pkg::*; #(
    parameter int HISTORY_BITS   = 15,
    parameter int ROW_INDEX_BITS = 9
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  command,
    input  wire logic [31:0]           pc,
    input  wire logic                  outcome,
    input  wire logic                  wr_en,
    input  wire logic [THRESH_W-1:0]   wr_data,
    output logic                       valid,
    output logic                       taken,
    output logic signed [SUM_W-1:0]    perceptron_sum
);

    localparam int ROW_LEN = HISTORY_BITS + 1;
    localparam int ROW_W   = ROW_LEN * WEIGHT_W;
    localparam int DEPTH   = 1 << ROW_INDEX_BITS;

    state_t                     state_reg;
    state_t                     state_next;
    logic [ROW_INDEX_BITS-1:0]  clear_cnt_reg;
    logic [ROW_INDEX_BITS-1:0]  clear_cnt_next;
    logic [HISTORY_BITS-1:0]    history_reg;
    logic [HISTORY_BITS-1:0]    history_next;
    logic [THRESH_W-1:0]        thresh_reg;
    logic                       cmd_reg;
    logic                       outcome_reg;
    logic [ROW_INDEX_BITS-1:0]  row_addr_reg;

    logic                       accept;
    logic [ROW_W-1:0]           rd_data;
    logic [ROW_W-1:0]           upd_row;
    logic                       ram_we;
    logic [ROW_INDEX_BITS-1:0]  ram_waddr;
    logic [ROW_W-1:0]           ram_wdata;
    logic                       dot_load;
    logic                       dot_done;
    logic signed [SUM_W-1:0]    last_sum;
    logic [SUM_W-1:0]           last_mag;
    logic                       wrong;
    logic                       do_train;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // training decision from the kept sum
    assign last_mag = last_sum[SUM_W-1] ? SUM_W'(-last_sum) : SUM_W'(last_sum);
    assign wrong    = (!last_sum[SUM_W-1] && !outcome_reg) ||
                      (last_sum[SUM_W-1] && outcome_reg);
    assign do_train = wrong || (last_mag <= {1'b0, thresh_reg});

    pbp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (pc[ROW_INDEX_BITS-1:0]),
        .rd_data (rd_data)
    );

    pbp_row_update #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_row_update (
        .row_in  (rd_data),
        .history (history_reg),
        .outcome (outcome_reg),
        .row_out (upd_row)
    );

    pbp_dot_unit #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_dot_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (dot_load),
        .row_data (rd_data),
        .history  (history_reg),
        .done     (dot_done),
        .sum      (last_sum)
    );

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        history_next   = history_reg;
        ram_we         = 1'b0;
        ram_waddr      = row_addr_reg;
        ram_wdata      = upd_row;
        dot_load       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we         = 1'b1;
                ram_waddr      = clear_cnt_reg;
                ram_wdata      = '0;
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cmd_reg == CMD_TRAIN)
                begin
                    ram_we       = do_train;
                    history_next = HISTORY_BITS'({history_reg, outcome_reg});
                    state_next   = ST_IDLE;
                end
                else
                begin
                    dot_load   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (dot_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            history_reg   <= '0;
            thresh_reg    <= THRESHOLD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            history_reg   <= history_next;
            if (wr_en)
            begin
                thresh_reg <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= command;
            outcome_reg  <= outcome;
            row_addr_reg <= pc[ROW_INDEX_BITS-1:0];
        end
    end

    assign valid          = dot_done;
    assign taken          = !last_sum[SUM_W-1];
    assign perceptron_sum = last_sum;

endmodule

`default_nettype wire

FILE: design/pbp_checker.sv
// port-level checks for the perceptron branch predictor, bound to the top level
`default_nettype none

`include "perceptron_branch_predictor_core_defines.svh"

module pbp_checker import pbp_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 command,
    input wire logic                 valid,
    input wire logic                 taken,
    input wire logic [SUM_W-1:0]     perceptron_sum
);

    // an accepted word always makes the block busy in the next cycle
    `PBP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // a train word never yields a result word
    `PBP_ASSERT_NEXT(a_train_silent, start && !busy && command == CMD_TRAIN, !valid)

    // result strobe lasts one cycle only
    `PBP_ASSERT_NEXT(a_valid_pulse, valid, !valid)

    // direction follows the sign of the sum
    `PBP_ASSERT_NOW(a_taken_sign, valid, taken == !perceptron_sum[SUM_W-1])

    // a result comes only while a predict word is in flight
    `PBP_ASSERT_NOW(a_valid_busy, valid, busy)

endmodule

bind perceptron_branch_predictor_core pbp_checker u_pbp_checker (.*);

`default_nettype wire
